// ===== hdl/tsr_pkg.sv =====
`timescale 1ns / 1ps

package tsr_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAW_W      = 16;
  localparam int PANEL_W    = 13;
  localparam int ROT_W      = 2;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int PROD_W     = RAW_W + PANEL_W + 1;
  localparam int QUOT_W     = PANEL_W;
  localparam int CNT_W      = $clog2(QUOT_W + 1);
  localparam int SIG_W      = RAW_W + 2;

  localparam logic [RAW_W-1:0]   RAW_WIDTH_RST     = RAW_W'(800);
  localparam logic [RAW_W-1:0]   RAW_HEIGHT_RST    = RAW_W'(480);
  localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST   = PANEL_W'(800);
  localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST  = PANEL_W'(480);
  localparam logic [PANEL_W-1:0] SCREEN_WIDTH_RST  = PANEL_W'(800);
  localparam logic [PANEL_W-1:0] SCREEN_HEIGHT_RST = PANEL_W'(480);

  typedef enum logic [2:0] {
    REG_RAW_WIDTH,
    REG_RAW_HEIGHT,
    REG_PANEL_WIDTH,
    REG_PANEL_HEIGHT,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT,
    REG_ROTATION
  } reg_idx_t;

  typedef enum logic [ROT_W-1:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270
  } rot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ROTATE,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic              touched;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
  } tsr_in_t;

  typedef struct packed {
    logic                  press_state;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
  } tsr_out_t;

  typedef struct packed {
    logic [RAW_W-1:0]   raw_width;
    logic [RAW_W-1:0]   raw_height;
    logic [PANEL_W-1:0] panel_width;
    logic [PANEL_W-1:0] panel_height;
    logic [PANEL_W-1:0] screen_width;
    logic [PANEL_W-1:0] screen_height;
    rot_t               rotation;
  } tsr_cfg_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [RAW_W-1:0]  divisor;
  } tsr_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } tsr_div_rsp_t;

endpackage

// ===== hdl/tsr_regs.sv =====
`timescale 1ns / 1ps

module tsr_regs import tsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output tsr_cfg_t          cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_width     <= RAW_WIDTH_RST;
      cfg.raw_height    <= RAW_HEIGHT_RST;
      cfg.panel_width   <= PANEL_WIDTH_RST;
      cfg.panel_height  <= PANEL_HEIGHT_RST;
      cfg.screen_width  <= SCREEN_WIDTH_RST;
      cfg.screen_height <= SCREEN_HEIGHT_RST;
      cfg.rotation      <= ROT_0;
    end else if (wr) begin
      case (idx)
        REG_RAW_WIDTH:     cfg.raw_width     <= pwdata[RAW_W-1:0];
        REG_RAW_HEIGHT:    cfg.raw_height    <= pwdata[RAW_W-1:0];
        REG_PANEL_WIDTH:   cfg.panel_width   <= pwdata[PANEL_W-1:0];
        REG_PANEL_HEIGHT:  cfg.panel_height  <= pwdata[PANEL_W-1:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[PANEL_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[PANEL_W-1:0];
        REG_ROTATION:      cfg.rotation      <= rot_t'(pwdata[ROT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RAW_WIDTH:     prdata = DATA_W'(cfg.raw_width);
      REG_RAW_HEIGHT:    prdata = DATA_W'(cfg.raw_height);
      REG_PANEL_WIDTH:   prdata = DATA_W'(cfg.panel_width);
      REG_PANEL_HEIGHT:  prdata = DATA_W'(cfg.panel_height);
      REG_SCREEN_WIDTH:  prdata = DATA_W'(cfg.screen_width);
      REG_SCREEN_HEIGHT: prdata = DATA_W'(cfg.screen_height);
      REG_ROTATION:      prdata = DATA_W'(cfg.rotation);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hdl/tsr_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit a cycle; quotient known to fit QUOT_W bits
module tsr_div import tsr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tsr_div_req_t req,
  output tsr_div_rsp_t rsp
);

  logic [RAW_W-1:0]  rem;
  logic [QUOT_W-1:0] q;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [RAW_W:0]    trial;
  logic [RAW_W:0]    diff;
  logic              ge;

  assign trial = {rem, q[QUOT_W-1]};
  assign diff  = trial - {1'b0, req.divisor};
  assign ge    = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[PROD_W-2:QUOT_W];
      q   <= req.dividend[QUOT_W-1:0];
    end else if (busy) begin
      rem <= ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
      q   <= {q[QUOT_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = q;

endmodule

// ===== hdl/tsr_seq.sv =====
`timescale 1ns / 1ps

module tsr_seq import tsr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tsr_cfg_t cfg,
  input  logic     sample_valid,
  output logic     sample_ready,
  input  tsr_in_t  sample,
  input  logic     out_free,
  output logic     out_load,
  output tsr_out_t out_word
);

  state_t state;
  state_t state_next;

  tsr_in_t               smp;
  logic                  axis;
  logic [RAW_W-1:0]      u_r;
  logic [PROD_W-1:0]     prod_r;
  logic [RAW_W-1:0]      px_r;
  logic [RAW_W-1:0]      py_r;
  logic [COORD_BITS-1:0] held_x;
  logic [COORD_BITS-1:0] held_y;

  logic signed [RAW_W-1:0] v_sel;
  logic [RAW_W-1:0]        raw_sel;
  logic [PANEL_W-1:0]      phys_sel;
  logic [RAW_W-1:0]        raw_m1;
  logic [RAW_W-1:0]        u;
  logic                    raw_big;
  logic                    rescale;
  logic [SIG_W-1:0]        x_rot;
  logic [SIG_W-1:0]        y_rot;
  logic [SIG_W-1:0]        px_s;
  logic [SIG_W-1:0]        py_s;
  logic [SIG_W-1:0]        wm1;
  logic [SIG_W-1:0]        hm1;

  tsr_div_req_t div_req;
  tsr_div_rsp_t div_rsp;

  function automatic logic [COORD_BITS-1:0] fit(input logic [SIG_W-1:0] v,
                                                input logic [PANEL_W-1:0] ext);
    logic [PANEL_W-1:0]    hi_e;
    logic [COORD_BITS-1:0] hi;
    logic [COORD_BITS-1:0] res;
    hi_e = (ext == '0) ? '0 : ext - 1'b1;
    if (hi_e > PANEL_W'({COORD_BITS{1'b1}}))
      hi = '1;
    else
      hi = hi_e[COORD_BITS-1:0];
    if (v[SIG_W-1])
      res = '0;
    else if (v > SIG_W'(hi))
      res = hi;
    else
      res = v[COORD_BITS-1:0];
    return res;
  endfunction

  // axis select and clamp
  assign v_sel    = axis ? smp.raw_y : smp.raw_x;
  assign raw_sel  = axis ? cfg.raw_height : cfg.raw_width;
  assign phys_sel = axis ? cfg.panel_height : cfg.panel_width;
  assign raw_m1   = raw_sel - 1'b1;
  assign raw_big  = raw_sel > RAW_W'(1);

  always_comb begin
    if (v_sel[RAW_W-1])
      u = '0;
    else
      u = {1'b0, v_sel[RAW_W-2:0]};
    if (raw_big && (u >= raw_sel))
      u = raw_m1;
  end

  assign rescale = raw_big && (phys_sel > PANEL_W'(1)) &&
                   (raw_sel != RAW_W'(phys_sel));

  assign div_req.start    = (state == ST_DIV_START);
  assign div_req.dividend = prod_r + PROD_W'(raw_m1 >> 1);
  assign div_req.divisor  = raw_m1;

  tsr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // rotation, two's complement in SIG_W bits
  assign px_s = SIG_W'(px_r);
  assign py_s = SIG_W'(py_r);
  assign wm1  = SIG_W'(cfg.panel_width) - 1'b1;
  assign hm1  = SIG_W'(cfg.panel_height) - 1'b1;

  always_comb begin
    case (cfg.rotation)
      ROT_90: begin
        x_rot = py_s;
        y_rot = wm1 - px_s;
      end
      ROT_180: begin
        x_rot = wm1 - px_s;
        y_rot = hm1 - py_s;
      end
      ROT_270: begin
        x_rot = hm1 - py_s;
        y_rot = px_s;
      end
      default: begin
        x_rot = px_s;
        y_rot = py_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_IDLE;
    else
      state <= state_next;
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid)
          state_next = sample.touched ? ST_CLAMP : ST_DELIVER;
      end
      ST_CLAMP: begin
        if (rescale)
          state_next = ST_MUL;
        else if (axis)
          state_next = ST_ROTATE;
      end
      ST_MUL:       state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done)
          state_next = axis ? ST_ROTATE : ST_CLAMP;
      end
      ST_ROTATE:    state_next = ST_DELIVER;
      ST_DELIVER: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
      axis   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          axis <= 1'b0;
        end
        ST_CLAMP: begin
          if (!rescale && !axis)
            axis <= 1'b1;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done && !axis)
            axis <= 1'b1;
        end
        ST_ROTATE: begin
          held_x <= fit(x_rot, cfg.screen_width);
          held_y <= fit(y_rot, cfg.screen_height);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid)
      smp <= sample;
    if (state == ST_CLAMP) begin
      u_r <= u;
      if (!rescale) begin
        if (axis)
          py_r <= u;
        else
          px_r <= u;
      end
    end
    if (state == ST_MUL)
      prod_r <= PROD_W'(u_r) * PROD_W'(phys_sel - 1'b1);
    if (state == ST_DIV_WAIT && div_rsp.done) begin
      if (axis)
        py_r <= RAW_W'(div_rsp.quotient);
      else
        px_r <= RAW_W'(div_rsp.quotient);
    end
  end

  assign out_word.press_state = smp.touched;
  assign out_word.point_x     = held_x;
  assign out_word.point_y     = held_y;

endmodule

// ===== hdl/touch_point_scale_rotate.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                      Word
// sample    in   sample_valid / sample_ready    tsr_in_t  (touched, raw_x, raw_y)
// result    out  result_valid / result_ready    tsr_out_t (press_state, point_x, point_y)
// config    in   APB psel/penable/pwrite/pready registers at 4*i
//
// A press runs from accept to result through, per axis, a clamp and, when the axis is
// rescaled, a multiply and a 13-step shared restoring divider (both axes in turn through
// the one divider), then rotate and deliver. A release goes straight to deliver. One
// sample in flight; sample_ready is high only when idle. A stalled result holds the
// sequencer in deliver, so the next sample waits. Synchronous reset restores register
// defaults and clears the held point.

module touch_point_scale_rotate import tsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  tsr_in_t           sample,
  output logic              result_valid,
  input  logic              result_ready,
  output tsr_out_t          result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  tsr_cfg_t cfg;
  logic     out_free;
  logic     out_load;
  tsr_out_t out_word;
  logic     result_valid_next;

  tsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsr_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .out_free     (out_free),
    .out_load     (out_load),
    .out_word     (out_word)
  );

  assign out_free = !result_valid || result_ready;

  always_comb begin
    result_valid_next = result_valid;
    if (result_valid && result_ready)
      result_valid_next = 1'b0;
    if (out_load)
      result_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst)
      result_valid <= 1'b0;
    else
      result_valid <= result_valid_next;
  end

  always_ff @(posedge clk) begin
    if (out_load)
      result <= out_word;
  end

endmodule
